// ===== rtl/core/pfps_pkg.sv =====
// Package for the packed FFT power spectrum block: widths, codes, controller/datapath structs.
// No dependencies.
package pfps_pkg;
   localparam int SampleWidth   = 16;
   localparam int PowerWidth    = 32;
   localparam int ValueWidth    = 33;
   localparam int BinWidth      = 12;
   localparam int SizeWidth     = 13;
   localparam int PairWidth     = 11;
   localparam int MaxFftSize    = 4096;
   localparam int DbSlopeQ16    = 394566;
   localparam int DbFloorQ8     = -25600;

   typedef enum logic [1:0] {
      MODE_POWER   = 2'd0,
      MODE_MAG     = 2'd1,
      MODE_DB      = 2'd2,
      MODE_DENSITY = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      CSR_MODE = 1'b0,
      CSR_SIZE = 1'b1
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic                     load;     // capture operands, start computing
      logic signed [SampleWidth-1:0] re;
      logic signed [SampleWidth-1:0] im;
      logic [BinWidth-1:0]      bin;
      logic                     last;
      mode_type                 mode;
      logic [BinWidth-1:0]      divisor_m1; // N/2 (divisor is N/2+1)
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic busy;
   } status_type;
endpackage

// ===== rtl/core/pfps_if.sv =====
// Valid/ready channel interfaces for the req and rsp sides, payload fields carried directly.
// Depends on nothing; field widths are fixed here.
interface pfps_req_if;
   logic                         valid;
   logic                         ready;
   logic signed [15:0]           first_word;
   logic signed [15:0]           second_word;
   modport source (output valid, first_word, second_word, input ready);
   modport sink   (input valid, first_word, second_word, output ready);
endinterface

interface pfps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [11:0]                  bin_number;
   logic signed [32:0]           bin_value;
   logic                         frame_last;
   modport source (output valid, bin_number, bin_value, frame_last, input ready);
   modport sink   (input valid, bin_number, bin_value, frame_last, output ready);
endinterface

// ===== rtl/core/pfps_datapath.sv =====
// Datapath: squares, iterative sqrt, log2 and restoring divider, output register.
// Depends on pfps_pkg and pfps_rsp_if.
module pfps_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pfps_pkg::cmd_type    cmd,
   output pfps_pkg::status_type status,
   pfps_rsp_if.source           rsp
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SQ   = 7'b0000010,
      S_SUM  = 7'b0000100,
      S_ITER = 7'b0001000,
      S_DB   = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_OUT  = 7'b1000000
   } dp_state_type;

   dp_state_type          state_ff, state_in;
   logic signed [15:0]    re_ff, im_ff;
   logic [31:0]           sq_re_ff, sq_im_ff;
   logic [32:0]           p_ff;          // power, up to 2^31
   logic [11:0]           bin_ff;
   logic                  last_ff;
   pfps_pkg::mode_type    mode_ff;
   logic [11:0]           dm1_ff;
   logic [5:0]            cnt_ff;
   // shared iteration registers
   logic [33:0]           rem_ff;        // sqrt remainder / divider remainder
   logic [33:0]           acc_ff;        // sqrt root / quotient / log mantissa
   logic [15:0]           frac_ff;
   logic [5:0]            exp_ff;
   logic signed [47:0]    db_ff;
   logic signed [32:0]    res_ff;
   logic [11:0]           obin_ff;
   logic signed [32:0]    oval_ff;
   logic                  olast_ff;
   logic                  ovalid_ff;
   logic                  ovalid_in;

   logic [33:0] trial;
   logic [63:0] msq;
   logic [33:0] dnew;
   logic [33:0] p2;
   logic [5:0]  topbit;
   logic [33:0] xp1;
   logic signed [47:0] dl;
   logic        iter_done;

   always_comb begin
      xp1 = {1'b0, p_ff} + 34'd1;
      topbit = '0;
      for (int i = 0; i < 34; i++) begin
         if (xp1[i]) topbit = 6'(i);
      end
   end

   assign trial = {rem_ff[31:0], p_ff[6'(2*cnt_ff+1) -: 2]} - {acc_ff[31:0], 2'b01};
   assign msq   = {32'd0, acc_ff[31:0]} * {32'd0, acc_ff[31:0]};
   // dividend is 2P: one extra zero bit below P
   assign p2    = {p_ff, 1'b0};
   assign dnew  = {rem_ff[32:0], p2[6'd33 - cnt_ff]};
   assign dl    = 48'(signed'({1'b0, exp_ff, frac_ff}) - 48'sd1966080);
   assign iter_done = (mode_ff == pfps_pkg::MODE_DENSITY) ? (cnt_ff == 6'd33)
                                                          : (cnt_ff == 6'd0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (cmd.load) state_in = S_SQ;
         S_SQ:   state_in = S_SUM;
         S_SUM:  state_in = (mode_ff == pfps_pkg::MODE_POWER) ? S_OUT : S_ITER;
         S_ITER: if (iter_done)
                    state_in = (mode_ff == pfps_pkg::MODE_DB) ? S_DB : S_FIN;
         S_DB:   state_in = S_FIN;
         S_FIN:  state_in = S_OUT;
         S_OUT:  if (!ovalid_ff || rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ovalid_in = ovalid_ff && !rsp.ready;
      if (state_ff == S_OUT && (!ovalid_ff || rsp.ready)) ovalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: if (cmd.load) begin
            re_ff <= cmd.re; im_ff <= cmd.im; bin_ff <= cmd.bin;
            last_ff <= cmd.last; mode_ff <= cmd.mode; dm1_ff <= cmd.divisor_m1;
         end
         S_SQ: begin
            sq_re_ff <= 32'(re_ff * re_ff);
            sq_im_ff <= 32'(im_ff * im_ff);
         end
         S_SUM: begin
            p_ff <= {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
            rem_ff <= '0; acc_ff <= '0; frac_ff <= '0;
            unique case (mode_ff)
               pfps_pkg::MODE_MAG: cnt_ff <= 6'd15;
               pfps_pkg::MODE_DB:  cnt_ff <= 6'd16;
               default:            cnt_ff <= 6'd0;
            endcase
         end
         S_ITER: begin
            unique case (mode_ff)
               pfps_pkg::MODE_MAG: begin
                  // one root bit per cycle, two radicand bits
                  if (!trial[33]) begin
                     rem_ff <= trial; acc_ff <= {acc_ff[32:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[31:0], p_ff[6'(2*cnt_ff+1) -: 2]};
                     acc_ff <= {acc_ff[32:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 6'd1;
               end
               pfps_pkg::MODE_DB: begin
                  if (cnt_ff == 6'd16) begin
                     // normalize x to 31 fraction bits
                     exp_ff <= topbit;
                     acc_ff <= (topbit > 6'd31) ? xp1 >> (topbit - 6'd31)
                                                : xp1 << (6'd31 - topbit);
                  end else if (msq[63:31] >= 33'h1_0000_0000) begin
                     acc_ff <= 34'(msq[63:32]); frac_ff <= {frac_ff[14:0], 1'b1};
                  end else begin
                     acc_ff <= 34'(msq[63:31]); frac_ff <= {frac_ff[14:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 6'd1;
               end
               default: begin
                  // restoring division of 2P by N/2+1, P shifted left 1
                  if (dnew >= {21'd0, dm1_ff + 13'd1}) begin
                     rem_ff <= dnew - {21'd0, dm1_ff + 13'd1};
                     acc_ff <= {acc_ff[32:0], 1'b1};
                  end else begin
                     rem_ff <= dnew; acc_ff <= {acc_ff[32:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 6'd1;
               end
            endcase
         end
         S_DB: db_ff <= dl * 48'sd394566;
         S_FIN: begin
            if (mode_ff == pfps_pkg::MODE_DB) begin
               if ((db_ff >>> 24) < 48'sd0 - 48'sd25600) res_ff <= -33'sd25600;
               else res_ff <= 33'(db_ff >>> 24);
            end else begin
               res_ff <= signed'(acc_ff[32:0]);
            end
         end
         S_OUT: if (!ovalid_ff || rsp.ready) begin
            obin_ff <= bin_ff; olast_ff <= last_ff;
            oval_ff <= (mode_ff == pfps_pkg::MODE_POWER) ? signed'(p_ff) : res_ff;
         end
         default: ;
      endcase
   end

   assign status.busy    = (state_ff != S_IDLE);
   assign rsp.valid      = ovalid_ff;
   assign rsp.bin_number = obin_ff;
   assign rsp.bin_value  = oval_ff;
   assign rsp.frame_last = olast_ff;
endmodule

// ===== rtl/core/pfps_ctrl.sv =====
// Controller: config registers, framing, Nyquist hold, issues bins to datapath.
// Depends on pfps_pkg and pfps_req_if.
module pfps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [0:0]           csr_index,
   input  logic [12:0]          csr_data,
   input  pfps_pkg::status_type status,
   output pfps_pkg::cmd_type    cmd,
   pfps_req_if.sink             req
);
   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_WAIT = 3'b010,
      C_NYQ  = 3'b100
   } ctrl_state_type;

   ctrl_state_type     state_ff, state_in;
   pfps_pkg::mode_type mode_ff;
   logic [12:0]        size_ff;
   logic [10:0]        pair_ff;
   logic [15:0]        nyq_ff;
   logic [11:0]        half;
   logic [10:0]        pos;
   logic               take;

   always_comb begin
      logic [12:0] n;
      n = size_ff;
      if (n < 13'd4) n = 13'd4;
      if (n > 13'd4096) n = 13'd4096;
      half = n[12:1];
   end

   assign pos  = ({1'b0, pair_ff} >= half) ? 11'd0 : pair_ff;
   assign take = req.valid && req.ready;
   assign req.ready = (state_ff == C_IDLE) && !status.busy;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.mode = mode_ff;
      cmd.divisor_m1 = half;
      unique case (state_ff)
         C_IDLE: if (take) begin
            cmd.load = 1'b1;
            cmd.re   = req.first_word;
            cmd.im   = (pos == 11'd0) ? 16'sd0 : req.second_word;
            cmd.bin  = {1'b0, pos};
            if (pos != 11'd0 && {1'b0, pos} == half - 12'd1) state_in = C_WAIT;
         end
         C_WAIT: if (!status.busy) state_in = C_NYQ;
         C_NYQ: begin
            cmd.load = 1'b1;
            cmd.re   = nyq_ff;
            cmd.bin  = half;
            cmd.last = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         mode_ff  <= pfps_pkg::MODE_POWER;
         size_ff  <= 13'd512;
         pair_ff  <= '0;
         nyq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               pfps_pkg::CSR_MODE: mode_ff <= pfps_pkg::mode_type'(csr_data[1:0]);
               pfps_pkg::CSR_SIZE: size_ff <= csr_data;
               default: ;
            endcase
         end
         if (take) begin
            if (pos == 11'd0) begin
               nyq_ff  <= req.second_word;
               pair_ff <= 11'd1;
            end else if ({1'b0, pos} == half - 12'd1) begin
               pair_ff <= '0;
            end else begin
               pair_ff <= pos + 11'd1;
            end
         end
      end
   end
endmodule

// ===== rtl/core/packed_fft_power_spectrum.sv =====
// Packed FFT power spectrum. req: word pairs of a packed real FFT frame;
// rsp: one bin result per transfer, DC first, Nyquist last with frame_last.
// csr: write mode (index 0) and fft_size (index 1) while idle.
// Each pair gives one bin; the last pair also gives the held Nyquist bin.
// Magnitude, decibel and density bins pass through the one shared iteration
// unit (root, log2 squaring, divider); power bins skip it. The next pair is
// taken once the datapath has moved its bin into the output register; after
// the last pair of a frame the Nyquist bin is computed before the next pair
// is taken.
// One bin is in work at a time; req.ready is low while a bin is computed.
// A finished bin sits in an output register; while the receiver stalls,
// one more pair is taken and its bin held back, then req.ready stays low
// until the register is taken.
// Reset clears mode to power, fft_size to 512 and frame position to pair 0.
// Depends on pfps_pkg, pfps_if, pfps_ctrl, pfps_datapath.
module packed_fft_power_spectrum (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_data,
   pfps_req_if.sink    req,
   pfps_rsp_if.source  rsp
);
   pfps_pkg::cmd_type    cmd;
   pfps_pkg::status_type status;

   pfps_ctrl u_ctrl (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .status, .cmd, .req
   );

   pfps_datapath u_dp (
      .clock, .reset, .cmd, .status, .rsp
   );

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.bin_value))
      else $error("result changed under stall");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req.ready)
      else $error("input taken while busy");
   a_last_bin: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.frame_last |-> rsp.bin_number != 12'd0)
      else $error("last flag on DC bin");
endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for packed_fft_power_spectrum: drives packed FFT word pairs,
// predicts every bin in all four modes and checks the rsp stream.
// Depends on pfps_pkg, pfps_if and the RTL top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] first_word;
      logic signed [15:0] second_word;
   } word_pair_type;

   typedef struct {
      logic [11:0] bin_number;
      logic [32:0] bin_value;
      logic        frame_last;
   } bin_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   pfps_req_if req ();
   pfps_rsp_if rsp ();

   packed_fft_power_spectrum dut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req(req.sink), .rsp(rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and frame state
   pfps_pkg::mode_type cur_mode = pfps_pkg::MODE_POWER;
   logic [12:0] cur_size = 13'd512;
   logic [10:0] frame_pos = '0;
   logic [15:0] held_nyquist = '0;

   word_pair_type  pending_pairs[$];
   bin_result_type spectrum_bins_due[$];
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          hold_len = 0;
   int          hold_seq = 0;
   int          pairs_sent = 0;
   int          bins_checked = 0;
   int          mismatches = 0;
   bit [3:0]    modes_seen = '0;

   function automatic longint unsigned effective_size();
      longint unsigned n = cur_size;
      if (n < 4) n = 4;
      if (n > pfps_pkg::MaxFftSize) n = pfps_pkg::MaxFftSize;
      return n;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint log2_fixed(longint unsigned x);
      int e = 63;
      longint unsigned m;
      longint unsigned frac = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      m = (e > 31) ? (x >> (e - 31)) : (x << (31 - e));
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return longint'(e) * 65536 + longint'(frac);
   endfunction

   function automatic logic [32:0] spectrum_value(longint re, longint im);
      longint unsigned p = longint'(re * re) + longint'(im * im);
      longint d;
      case (cur_mode)
         pfps_pkg::MODE_POWER: return p[32:0];
         pfps_pkg::MODE_MAG:   return 33'(floor_sqrt(p));
         pfps_pkg::MODE_DB: begin
            // arithmetic shift floors negative values
            d = (log2_fixed(p + 1) - 30 * 65536) * longint'(pfps_pkg::DbSlopeQ16);
            d = d >>> 24;
            if (d < pfps_pkg::DbFloorQ8) d = pfps_pkg::DbFloorQ8;
            return d[32:0];
         end
         default: return 33'((2 * p) / (effective_size() / 2 + 1));
      endcase
   endfunction

   function automatic void predict_pair(logic signed [15:0] a, logic signed [15:0] b);
      longint unsigned half = effective_size() / 2;
      bin_result_type r;
      modes_seen[cur_mode] = 1'b1;
      if (frame_pos >= half) frame_pos = '0;
      if (frame_pos == 0) begin
         r.bin_number = '0;
         r.bin_value = spectrum_value(a, 0);
         r.frame_last = 1'b0;
         spectrum_bins_due.push_back(r);
         held_nyquist = b;
         frame_pos = 11'd1;
         return;
      end
      r.bin_number = 12'(frame_pos);
      r.bin_value = spectrum_value(a, b);
      r.frame_last = 1'b0;
      spectrum_bins_due.push_back(r);
      if (frame_pos == half - 1) begin
         r.bin_number = 12'(half);
         r.bin_value = spectrum_value($signed(held_nyquist), 0);
         r.frame_last = 1'b1;
         spectrum_bins_due.push_back(r);
         frame_pos = '0;
      end else begin
         frame_pos = frame_pos + 11'd1;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      word_pair_type w;
      if (reset) begin
         req.valid <= 1'b0;
         req.first_word <= '0;
         req.second_word <= '0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) predict_pair(req.first_word, req.second_word);
         if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            w = pending_pairs.pop_front();
            req.valid <= 1'b1;
            req.first_word <= w.first_word;
            req.second_word <= w.second_word;
            pairs_sent++;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor and receiver ready
   int hold_left = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      bin_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         bins_checked++;
         if (spectrum_bins_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected bin %0d value %0d", rsp.bin_number, rsp.bin_value);
         end else begin
            e = spectrum_bins_due.pop_front();
            if (rsp.bin_number !== e.bin_number || rsp.bin_value !== e.bin_value
                || rsp.frame_last !== e.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("bin mismatch: expected bin %0d value %0d last %0b, got %0d %0d %0b",
                           e.bin_number, $signed(e.bin_value), e.frame_last,
                           rsp.bin_number, rsp.bin_value, rsp.frame_last);
            end
         end
      end
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic write_reg(pfps_pkg::csr_index_type idx, logic [12:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      if (idx == pfps_pkg::CSR_MODE) cur_mode = pfps_pkg::mode_type'(v[1:0]);
      else cur_size = v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (pending_pairs.size() != 0 || req.valid || spectrum_bins_due.size() != 0)
         @(posedge clock);
      // density has the longest bin computation
      repeat (60) @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_word();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void add_pair(logic signed [15:0] a, logic signed [15:0] b);
      word_pair_type w;
      w.first_word = a;
      w.second_word = b;
      pending_pairs.push_back(w);
   endfunction

   function automatic void add_extremes();
      add_pair(16'sh8000, 16'sh7fff);
      add_pair(16'sh8000, 16'sh8000);
      add_pair(16'sh7fff, 16'sh8000);
      add_pair(16'sh0000, 16'sh0000);
   endfunction

   initial begin
      pfps_pkg::mode_type m;
      logic [12:0] sz;
      int n;
      int phases = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes in every mode on the smallest frame
      tx_idle_pct = 7;
      rx_idle_pct = 52;
      write_reg(pfps_pkg::CSR_SIZE, 13'd4);
      for (int k = 0; k < 4; k++) begin
         write_reg(pfps_pkg::CSR_MODE, 13'(k));
         add_extremes();
         drain();
      end
      // lengths out of range, then a length change and a mode change mid-frame
      write_reg(pfps_pkg::CSR_SIZE, 13'd0);
      add_pair(16'sh1234, 16'sh7fff);
      add_pair(16'sh8000, 16'sh0001);
      drain();
      write_reg(pfps_pkg::CSR_SIZE, 13'd5);
      add_pair(16'sh0001, 16'sh8000);
      add_pair(16'shffff, 16'sh7fff);
      drain();
      write_reg(pfps_pkg::CSR_SIZE, 13'd8191);
      add_pair(16'sh7fff, 16'sh4000);
      add_pair(16'sh0100, 16'shff00);
      add_pair(16'sh8001, 16'sh7ffe);
      drain();
      write_reg(pfps_pkg::CSR_SIZE, 13'd6);
      add_pair(16'sh5555, 16'shaaaa);
      drain();
      write_reg(pfps_pkg::CSR_MODE, 13'(pfps_pkg::MODE_POWER));
      add_pair(16'sh0003, 16'sh0004);
      add_pair(16'sh7fff, 16'sh7fff);
      drain();

      // random phases
      while (pairs_sent < 1450) begin
         if (pairs_sent < 480) begin
            tx_idle_pct = 7;
            rx_idle_pct = 52;
         end else if (pairs_sent < 960) begin
            tx_idle_pct = 52;
            rx_idle_pct = 7;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         m = pfps_pkg::mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0: sz = 13'($urandom_range(0, 3));
            1: sz = 13'($urandom_range(4097, 8191));
            2: sz = 13'($urandom_range(5, 41)) | 13'd1;
            default: sz = 13'd2 << $urandom_range(1, 5);
         endcase
         n = $urandom_range(20, 100);
         if (phases == 3) begin
            // one stretch on the largest frame, covering part of it
            sz = 13'd4096;
            n = 260;
         end
         write_reg(pfps_pkg::CSR_MODE, 13'(m));
         write_reg(pfps_pkg::CSR_SIZE, sz);
         for (int i = 0; i < n; i++) add_pair(random_word(), random_word());
         if (phases == 1) begin
            hold_len = 400;
            hold_seq++;
         end
         drain();
         phases++;
      end

      $display("%0d word pairs sent, %0d bins checked over %0d random phases",
               pairs_sent, bins_checked, phases);
      $display("modes exercised (bit per mode): %b", modes_seen);
      if (mismatches == 0 && spectrum_bins_due.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d bins outstanding", spectrum_bins_due.size());
      $display("testbench NOT OK");
      $finish;
   end
endmodule
